// ===== design/xcd_pkg.sv =====
// ----------------------------------------------------------------------------
// XOR-checked command deframer package
// Shared constants, payload types and the command prefix matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package xcd_pkg;

  // Largest frame before the gathering restarts at the current byte.
  localparam int unsigned FRAME_BYTES = 64;

  // Byte counter width: it must be able to hold FRAME_BYTES itself.
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

  // Widths fixed by the word format.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned LEN_W  = 7;

  // Candidate commands and the flag bit that tracks each of them.
  localparam int unsigned CAND_COUNT     = 4;
  localparam int unsigned CAND_STATUS    = 0;
  localparam int unsigned CAND_PING      = 1;
  localparam int unsigned CAND_CFG_READ  = 2;
  localparam int unsigned CAND_CFG_WRITE = 3;

  // Command codes reported in the result word.
  localparam logic [CODE_W-1:0] CMD_UNKNOWN   = 3'd0;
  localparam logic [CODE_W-1:0] CMD_STATUS    = 3'd1;
  localparam logic [CODE_W-1:0] CMD_PING      = 3'd2;
  localparam logic [CODE_W-1:0] CMD_CFG_READ  = 3'd3;
  localparam logic [CODE_W-1:0] CMD_CFG_WRITE = 3'd4;

  // Special byte values.
  localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;

  // Candidate text, padded with zeros to a power-of-two row length.
  localparam int unsigned TEXT_DEPTH = 16;
  localparam int unsigned TEXT_AW    = $clog2(TEXT_DEPTH);

  localparam logic [BYTE_W-1:0] CAND_TEXT [CAND_COUNT][TEXT_DEPTH] = '{
    '{"g", "e", "t", "_", "r", "e", "p", "o", "r", "t", "\n",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "i", "n", "g", "\n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "e", "t", "_", "p", "a", "r", "a", "m", "s", "\n",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "e", "t", "_", "p", "a", "r", "a", "m", 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int unsigned CAND_LEN [CAND_COUNT] = '{11, 5, 11, 9};

  // Input word: one received byte plus the transmitter state.
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_busy;
  } in_word_t;

  // Result word: decoded command, accepted flag and frame length.
  typedef struct packed {
    logic [CODE_W-1:0] command_code;
    logic              accepted;
    logic [LEN_W-1:0]  frame_length;
  } out_word_t;

  // Result handed from the frame logic to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

  // Update the match flags with the byte at position pos of the frame.
  // Exact commands drop out once the frame runs past their length.
  function automatic logic [CAND_COUNT-1:0] match_next(
    input logic [CAND_COUNT-1:0] flags,
    input logic [CNT_W-1:0]      pos,
    input logic [BYTE_W-1:0]     b
  );
    logic [CAND_COUNT-1:0] f;
    f = flags;
    for (int i = 0; i < CAND_COUNT; i++) begin
      if (pos < CNT_W'(CAND_LEN[i])) begin
        if (b != CAND_TEXT[i][pos[TEXT_AW-1:0]]) begin
          f[i] = 1'b0;
        end
      end else if (i != CAND_CFG_WRITE) begin
        f[i] = 1'b0;
      end
    end
    return f;
  endfunction

  // Pick the command from the final flags and the frame length.
  function automatic logic [CODE_W-1:0] decode_command(
    input logic [CAND_COUNT-1:0] flags,
    input logic [CNT_W-1:0]      len
  );
    logic [CODE_W-1:0] code;
    if (flags[CAND_STATUS] && len == CNT_W'(CAND_LEN[CAND_STATUS])) begin
      code = CMD_STATUS;
    end else if (flags[CAND_PING] && len == CNT_W'(CAND_LEN[CAND_PING])) begin
      code = CMD_PING;
    end else if (flags[CAND_CFG_READ] &&
                 len == CNT_W'(CAND_LEN[CAND_CFG_READ])) begin
      code = CMD_CFG_READ;
    end else if (flags[CAND_CFG_WRITE] &&
                 len >= CNT_W'(CAND_LEN[CAND_CFG_WRITE])) begin
      code = CMD_CFG_WRITE;
    end else begin
      code = CMD_UNKNOWN;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/xcd_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one incoming word until the frame logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module xcd_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire xcd_pkg::in_word_t in_word_i,
  input  wire logic             advance_i,
  output logic                  held_valid_o,
  output xcd_pkg::in_word_t     held_word_o
);

  logic              valid_q;
  logic              valid_d;
  xcd_pkg::in_word_t word_q;
  logic              load;

  // The register takes a new word whenever it is empty or being drained.
  assign load       = ~valid_q | advance_i;
  assign in_stall_o = ~load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_word_o  = word_q;

endmodule

`default_nettype wire

// ===== design/xcd_frame.sv =====
// ----------------------------------------------------------------------------
// Frame tracker
// Gathers bytes into a frame, keeps the running XOR and the command match
// flags, checks the trailer and produces at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xcd_frame (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire xcd_pkg::in_word_t word_i,
  output xcd_pkg::result_t       result_o
);

  // Phase codes.
  localparam logic [1:0] PH_RECV  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  localparam logic [xcd_pkg::CAND_COUNT-1:0] ALL_FLAGS = '1;

  logic [1:0]                      phase_q, phase_d;
  logic [xcd_pkg::BYTE_W-1:0]      chk_q, chk_d;
  logic [xcd_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [xcd_pkg::CAND_COUNT-1:0]  flags_q, flags_d;

  logic                            overflow;
  logic [xcd_pkg::BYTE_W-1:0]      base_chk;
  logic [xcd_pkg::CNT_W-1:0]       base_cnt;
  logic [xcd_pkg::CAND_COUNT-1:0]  base_flags;
  logic [xcd_pkg::BYTE_W-1:0]      b;

  assign b = word_i.rx_byte;

  // A full frame restarts at the current byte.
  assign overflow   = cnt_q >= xcd_pkg::CNT_W'(xcd_pkg::FRAME_BYTES);
  assign base_cnt   = overflow ? '0 : cnt_q;
  assign base_chk   = overflow ? '0 : chk_q;
  assign base_flags = overflow ? ALL_FLAGS : flags_q;

  // Next state and the result for the byte being consumed.
  always_comb begin
    phase_d  = phase_q;
    chk_d    = chk_q;
    cnt_d    = cnt_q;
    flags_d  = flags_q;
    result_o.valid             = 1'b0;
    result_o.word.command_code = xcd_pkg::decode_command(flags_q, cnt_q);
    result_o.word.accepted     = ~word_i.tx_busy;
    result_o.word.frame_length = xcd_pkg::LEN_W'(cnt_q);
    if (advance_i) begin
      unique case (phase_q)
        PH_RECV: begin
          flags_d = xcd_pkg::match_next(base_flags, base_cnt, b);
          cnt_d   = base_cnt + xcd_pkg::CNT_W'(1);
          chk_d   = base_chk ^ b;
          if (b == xcd_pkg::BYTE_NEWLINE) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (chk_q == b) begin
            phase_d = PH_END;
          end else begin
            phase_d = PH_RECV;
            chk_d   = '0;
            cnt_d   = '0;
            flags_d = ALL_FLAGS;
          end
        end
        PH_END: begin
          result_o.valid = (b == xcd_pkg::BYTE_ZERO);
          phase_d = PH_RECV;
          chk_d   = '0;
          cnt_d   = '0;
          flags_d = ALL_FLAGS;
        end
        default: begin
          phase_d = PH_RECV;
          chk_d   = '0;
          cnt_d   = '0;
          flags_d = ALL_FLAGS;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RECV;
      chk_q   <= '0;
      cnt_q   <= '0;
      flags_q <= ALL_FLAGS;
    end else begin
      phase_q <= phase_d;
      chk_q   <= chk_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

`ifndef SYNTH
  // The frame counter never passes the frame size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= xcd_pkg::CNT_W'(xcd_pkg::FRAME_BYTES))
    else $error("frame byte count beyond frame size");

  // Waiting for the check byte implies the newline was counted.
  a_check_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHECK |-> cnt_q != '0)
    else $error("check phase with empty frame");

  // A result leaves the tracker cleared for the next frame.
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |=> phase_q == PH_RECV && cnt_q == '0 && chk_q == '0 &&
                       flags_q == ALL_FLAGS)
    else $error("state not cleared after result");

  // A bad check byte drops the frame.
  a_bad_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_q == PH_CHECK && b != chk_q |=>
      phase_q == PH_RECV && cnt_q == '0)
    else $error("frame kept after check mismatch");
`endif

endmodule

`default_nettype wire

// ===== design/xcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// Output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module xcd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xcd_pkg::result_t  result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output xcd_pkg::out_word_t     out_word_o
);

  logic               valid_q;
  logic               valid_d;
  xcd_pkg::out_word_t word_q;

  // Free when empty or when the held word leaves this cycle.
  assign ready_o = ~valid_q | ~out_stall_i;
  assign valid_d = ready_o ? result_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && result_i.valid) begin
      word_q <= result_i.word;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== design/xor_checked_command_deframer_top.sv =====
// ----------------------------------------------------------------------------
// XOR-checked command deframer
// Takes received bytes, checks frames against a trailing XOR byte and a zero
// end byte, and reports the recognized command with the frame length.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                 | Word
//   --------+-----------+---------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o   | rx_byte, tx_busy
//   out     | output    | out_valid_o / out_stall_i | command_code, accepted,
//           |           |                           | frame_length
//
// A byte is taken every cycle unless in_stall_o is high; a result word is
// offered once its byte has passed the input and then the output register.
// The frame state advances once per byte in a single pass of compare, XOR and
// count logic, which sets the one-byte-per-cycle rate.
// Reset clears the frame state and both registers at once; no clearing pass.
// A stalled output stops the input register from draining, so in_stall_o
// rises only while a held result waits and another byte is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_command_deframer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire xcd_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output xcd_pkg::out_word_t      out_word_o
);

  logic              held_valid;
  xcd_pkg::in_word_t held_word;
  logic              out_ready;
  logic              advance;
  xcd_pkg::result_t  result;

  // A held byte is consumed when the output register can take its result.
  assign advance = held_valid & out_ready;

  xcd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_word_o  (held_word)
  );

  xcd_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .word_i    (held_word),
    .result_o  (result)
  );

  xcd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the XOR-checked command deframer
// Sends command frames, near misses, long and overflowing frames, broken check
// and end bytes and line noise under several sender and receiver idle mixes,
// and checks every result word against a predictor of the frame logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Where the predictor stands within a frame.
  typedef enum logic [1:0] {
    PH_GATHER  = 2'd0,
    PH_CHECK   = 2'd1,
    PH_TRAILER = 2'd2
  } frame_phase_e;

  // How a frame is closed after its newline.
  typedef enum int {
    TAIL_GOOD,
    TAIL_BAD_CHECK,
    TAIL_BAD_END
  } frame_tail_e;

  // Scoreboard: tracks the frame state and holds the commands still awaited.
  class command_scoreboard;
    frame_phase_e                   phase;
    logic [xcd_pkg::BYTE_W-1:0]     running_xor;
    int unsigned                    frame_len;
    logic [xcd_pkg::CAND_COUNT-1:0] live;
    string                          cand_text [xcd_pkg::CAND_COUNT];
    xcd_pkg::out_word_t             awaited [$];
    int unsigned                    errors;

    function new();
      cand_text = '{{"get_", "report\n"}, "ping\n", {"get_", "params\n"},
                    {"set_", "param"}};
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_GATHER;
      running_xor = '0;
      frame_len = 0;
      live = '1;
    endfunction

    function bit at_rest();
      return phase == PH_GATHER && frame_len == 0;
    endfunction

    // Exact commands need the full length; the parameter write only needs
    // its prefix.
    function logic [xcd_pkg::CODE_W-1:0] command_of();
      if (live[xcd_pkg::CAND_STATUS] &&
          frame_len == cand_text[xcd_pkg::CAND_STATUS].len()) begin
        return xcd_pkg::CMD_STATUS;
      end
      if (live[xcd_pkg::CAND_PING] &&
          frame_len == cand_text[xcd_pkg::CAND_PING].len()) begin
        return xcd_pkg::CMD_PING;
      end
      if (live[xcd_pkg::CAND_CFG_READ] &&
          frame_len == cand_text[xcd_pkg::CAND_CFG_READ].len()) begin
        return xcd_pkg::CMD_CFG_READ;
      end
      if (live[xcd_pkg::CAND_CFG_WRITE] &&
          frame_len >= cand_text[xcd_pkg::CAND_CFG_WRITE].len()) begin
        return xcd_pkg::CMD_CFG_WRITE;
      end
      return xcd_pkg::CMD_UNKNOWN;
    endfunction

    // Advance the frame state by one accepted word.
    function void note_byte(xcd_pkg::in_word_t w);
      string              s;
      xcd_pkg::out_word_t r;
      case (phase)
        PH_GATHER: begin
          // A full frame restarts at the current byte.
          if (frame_len >= xcd_pkg::FRAME_BYTES) begin
            restart();
          end
          for (int i = 0; i < xcd_pkg::CAND_COUNT; i++) begin
            s = cand_text[i];
            if (frame_len < s.len()) begin
              if (w.rx_byte != xcd_pkg::BYTE_W'(s[frame_len])) begin
                live[i] = 1'b0;
              end
            end else if (i != xcd_pkg::CAND_CFG_WRITE) begin
              live[i] = 1'b0;
            end
          end
          frame_len++;
          running_xor ^= w.rx_byte;
          if (w.rx_byte == xcd_pkg::BYTE_NEWLINE) begin
            phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (w.rx_byte == running_xor) begin
            phase = PH_TRAILER;
          end else begin
            restart();
          end
        end
        default: begin
          if (phase == PH_TRAILER && w.rx_byte == xcd_pkg::BYTE_ZERO) begin
            r.command_code = command_of();
            r.accepted     = ~w.tx_busy;
            r.frame_length = xcd_pkg::LEN_W'(frame_len);
            awaited.push_back(r);
          end
          restart();
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one result word with the oldest awaited command.
    task check_result(xcd_pkg::out_word_t got);
      xcd_pkg::out_word_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %p", got));
      end else begin
        want = awaited.pop_front();
        if (got.command_code != want.command_code) begin
          report_mismatch($sformatf("command_code %0d, wanted %0d",
                                    got.command_code, want.command_code));
        end
        if (got.accepted != want.accepted) begin
          report_mismatch($sformatf("accepted %0d, wanted %0d",
                                    got.accepted, want.accepted));
        end
        if (got.frame_length != want.frame_length) begin
          report_mismatch($sformatf("frame_length %0d, wanted %0d",
                                    got.frame_length, want.frame_length));
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  xcd_pkg::in_word_t  in_word   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  xcd_pkg::out_word_t out_word;

  command_scoreboard sb;
  int unsigned       items_sent = 0;
  int unsigned       idle_pct   = 0;
  int unsigned       stall_pct  = 0;

  xor_checked_command_deframer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver side: random stalls at the current pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_word);
    end
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one word, wait for it to be taken, then maybe idle a while.
  task automatic send_byte(input logic [xcd_pkg::BYTE_W-1:0] b, input logic busy);
    xcd_pkg::in_word_t w;
    w.rx_byte = b;
    w.tx_busy = busy;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_byte(w);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic logic [xcd_pkg::BYTE_W-1:0] body_byte();
    logic [xcd_pkg::BYTE_W-1:0] b;
    b = xcd_pkg::BYTE_W'($urandom_range(255));
    if (b == xcd_pkg::BYTE_NEWLINE) begin
      b = ~b;
    end
    return b;
  endfunction

  // Send a body, its newline and the closing bytes. The check byte comes from
  // the tracked frame state, so restarts after overflow are covered too.
  task automatic send_frame(input logic [xcd_pkg::BYTE_W-1:0] body [$],
                            input frame_tail_e tail, input logic busy);
    logic [xcd_pkg::BYTE_W-1:0] chk;
    foreach (body[i]) begin
      send_byte(body[i], 1'($urandom_range(1)));
    end
    send_byte(xcd_pkg::BYTE_NEWLINE, 1'($urandom_range(1)));
    chk = sb.running_xor;
    case (tail)
      TAIL_GOOD: begin
        send_byte(chk, 1'($urandom_range(1)));
        send_byte(xcd_pkg::BYTE_ZERO, busy);
      end
      TAIL_BAD_CHECK: begin
        send_byte(chk ^ xcd_pkg::BYTE_W'($urandom_range(1, 255)), 1'($urandom_range(1)));
      end
      default: begin
        send_byte(chk, 1'($urandom_range(1)));
        send_byte(xcd_pkg::BYTE_W'($urandom_range(1, 255)), busy);
      end
    endcase
  endtask

  task automatic send_text(input string s, input frame_tail_e tail, input logic busy);
    logic [xcd_pkg::BYTE_W-1:0] body [$];
    for (int i = 0; i < s.len(); i++) begin
      body.push_back(xcd_pkg::BYTE_W'(s[i]));
    end
    send_frame(body, tail, busy);
  endtask

  // Steer the block back to an empty frame after noise.
  task automatic return_to_rest();
    while (!sb.at_rest()) begin
      case (sb.phase)
        PH_GATHER: send_byte(xcd_pkg::BYTE_NEWLINE, 1'b0);
        PH_CHECK:  send_byte(~sb.running_xor, 1'b0);
        default:   send_byte(8'hFF, 1'b0);
      endcase
    end
  endtask

  // One random frame: commands, near misses, plain text, long or overflowing.
  task automatic send_random_frame();
    logic [xcd_pkg::BYTE_W-1:0] body [$];
    string                      txt;
    int                         pick;
    int                         pos;
    int                         n;
    frame_tail_e                tail;
    logic                       busy;
    string                      names [xcd_pkg::CAND_COUNT];
    names = '{{"get_", "report"}, "ping", {"get_", "params"}, {"set_", "param"}};
    pick = $urandom_range(99);
    if (pick < 30) begin
      txt = names[$urandom_range(xcd_pkg::CAND_CFG_READ)];
      for (int i = 0; i < txt.len(); i++) body.push_back(xcd_pkg::BYTE_W'(txt[i]));
    end else if (pick < 45) begin
      txt = names[xcd_pkg::CAND_CFG_WRITE];
      for (int i = 0; i < txt.len(); i++) body.push_back(xcd_pkg::BYTE_W'(txt[i]));
      n = $urandom_range(12);
      repeat (n) body.push_back(body_byte());
    end else if (pick < 65) begin
      // Near miss: one byte replaced, dropped or added.
      txt = names[$urandom_range(xcd_pkg::CAND_COUNT - 1)];
      for (int i = 0; i < txt.len(); i++) body.push_back(xcd_pkg::BYTE_W'(txt[i]));
      case ($urandom_range(2))
        0: begin
          pos = $urandom_range(body.size() - 1);
          n = int'(body_byte());
          body[pos] = (xcd_pkg::BYTE_W'(n) == body[pos]) ? (body[pos] ^ 8'h20) :
                                                           xcd_pkg::BYTE_W'(n);
        end
        1: body.delete($urandom_range(body.size() - 1));
        default: body.insert($urandom_range(body.size()), body_byte());
      endcase
    end else if (pick < 88) begin
      n = $urandom_range(15);
      repeat (n) body.push_back(body_byte());
    end else if (pick < 95) begin
      n = $urandom_range(40, xcd_pkg::FRAME_BYTES - 1);
      repeat (n) body.push_back(body_byte());
    end else begin
      // Overflow: the frame restarts, sometimes right at a command.
      if ($urandom_range(1) == 1) begin
        repeat (xcd_pkg::FRAME_BYTES) body.push_back(body_byte());
        txt = names[$urandom_range(xcd_pkg::CAND_COUNT - 1)];
        for (int i = 0; i < txt.len(); i++) body.push_back(xcd_pkg::BYTE_W'(txt[i]));
      end else begin
        n = $urandom_range(xcd_pkg::FRAME_BYTES, 120);
        repeat (n) body.push_back(body_byte());
      end
    end
    n = $urandom_range(99);
    tail = (n < 84) ? TAIL_GOOD : (n < 92) ? TAIL_BAD_CHECK : TAIL_BAD_END;
    busy = ($urandom_range(3) == 0);
    send_frame(body, tail, busy);
  endtask

  task automatic run_random_phase(input int unsigned send_idle, input int unsigned recv_stall,
                                  input int unsigned n_items);
    int unsigned stop_at;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // Line noise: any byte values, then back to an empty frame.
        repeat ($urandom_range(1, 8)) begin
          send_byte(xcd_pkg::BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        return_to_rest();
      end else begin
        send_random_frame();
      end
    end
  endtask

  initial begin
    logic [xcd_pkg::BYTE_W-1:0] body [$];
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: every command, busy transmitter, near misses, the
    // empty frame, broken check and end bytes, byte extremes, a zero check
    // byte, the longest frame and an overflow that restarts on a command.
    send_text({"get_", "report"}, TAIL_GOOD, 1'b0);
    send_text("ping", TAIL_GOOD, 1'b1);
    send_text({"get_", "params"}, TAIL_GOOD, 1'b0);
    send_text({"set_", "param"}, TAIL_GOOD, 1'b1);
    send_text({"set_", "param=7"}, TAIL_GOOD, 1'b0);
    send_text("", TAIL_GOOD, 1'b0);
    send_text("get_repor", TAIL_GOOD, 1'b0);
    send_text("pingg", TAIL_GOOD, 1'b0);
    send_text({"get_", "paramsx"}, TAIL_GOOD, 1'b1);
    send_text("ping", TAIL_BAD_CHECK, 1'b0);
    send_text("ping", TAIL_BAD_END, 1'b0);
    body = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_frame(body, TAIL_GOOD, 1'b0);
    body = '{8'h01, 8'h0B};
    send_frame(body, TAIL_GOOD, 1'b0);
    body = '{"s", "e", "t", "_", "p", "a", "r", "a", "m"};
    while (body.size() < xcd_pkg::FRAME_BYTES - 1) body.push_back(body_byte());
    send_frame(body, TAIL_GOOD, 1'b0);
    body = {};
    repeat (xcd_pkg::FRAME_BYTES) body.push_back(8'hFF);
    body.push_back("p");
    body.push_back("i");
    body.push_back("n");
    body.push_back("g");
    send_frame(body, TAIL_GOOD, 1'b1);

    run_random_phase(0, 0, 160);
    run_random_phase(84, 0, 160);
    run_random_phase(0, 84, 160);
    run_random_phase(23, 23, 160);
    in_valid <= 1'b0;

    // Drain the outstanding commands, then allow for the output latency.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
